// File: design/psbs_pkg.sv
package psbs_pkg;

  localparam int unsigned PACKET_SAMPLES_DEF = 512;

  localparam int unsigned FRAME_W = 11;
  localparam int unsigned DRIVE_AW = 10;
  localparam int unsigned CAP_AW = 11;

  typedef enum logic [2:0] {
    OP_ARM      = 3'd0,
    OP_TICK     = 3'd1,
    OP_IN_DONE  = 3'd2,
    OP_OUT_DONE = 3'd3,
    OP_FRAME    = 3'd4,
    OP_STOP     = 3'd5
  } op_e;

  localparam logic REG_INTERLEAVE = 1'b0;
  localparam logic REG_START_FRAME = 1'b1;

  typedef struct packed {
    op_e                op;
    logic               status_ok;
    logic [FRAME_W-1:0] frame;
  } event_t;

  typedef struct packed {
    logic                sample_valid;
    logic                channel;
    logic [DRIVE_AW-1:0] drive_addr;
    logic [CAP_AW-1:0]   volt_addr;
    logic [CAP_AW-1:0]   curr_addr;
    logic                issue_in;
    logic                issue_in_buffer;
    logic                issue_out;
    logic                issue_out_buffer;
    logic                running;
  } result_t;

  typedef struct packed {
    logic               reg_idx;
    logic [FRAME_W-1:0] wdata;
  } cfg_req_t;

endpackage

// File: design/psbs_stream_if.sv
interface psbs_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/pingpong_sample_buffer_sequencer_unit.sv
// each result is registered into the output register pair as its request is accepted
// throughput: one request per cycle while input ready is high; all event handling is one pass of short
//   logic from the state registers into a two-entry output register pair
// a stalled output side fills the second entry, then input ready drops
// reset (async, active low) clears the sequencer state, both config
//   registers and the output valid flags
module pingpong_sample_buffer_sequencer_unit #(
  parameter int unsigned PacketSamples = psbs_pkg::PACKET_SAMPLES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  psbs_stream_if.sink   cfg_i,
  psbs_stream_if.sink   in_i,
  psbs_stream_if.source out_o
);

  localparam int unsigned CntW = $clog2(PacketSamples + 1);
  localparam int unsigned AddrW = (CntW + 2 > psbs_pkg::CAP_AW) ? CntW + 2 : psbs_pkg::CAP_AW;
  localparam logic [CntW-1:0] CntFull = CntW'(PacketSamples);
  localparam logic [CntW-1:0] CntRefill = CntW'(PacketSamples / 2 - 2);
  localparam logic [AddrW-1:0] HalfW = AddrW'(PacketSamples / 2);
  localparam logic [AddrW-1:0] PktW = AddrW'(PacketSamples);
  localparam logic [AddrW-1:0] Pkt2W = AddrW'(2 * PacketSamples);

  // config registers
  logic                          interleave_q;
  logic [psbs_pkg::FRAME_W-1:0]  start_frame_q;

  // sequencer state
  logic            active_buf_q, active_buf_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            cur_ch_q, cur_ch_d;
  logic            in_sbuf_q, in_sbuf_d;
  logic            out_sbuf_q, out_sbuf_d;
  logic            in_req_q, in_req_d;
  logic            out_req_q, out_req_d;
  logic            in_busy_q, in_busy_d;
  logic            out_busy_q, out_busy_d;
  logic            first_out_q, first_out_d;
  logic            start_pend_q, start_pend_d;
  logic            timer_on_q, timer_on_d;

  // output register pair
  logic              out_vld_q, skid_vld_q;
  psbs_pkg::result_t out_q, skid_q;
  psbs_pkg::result_t res;

  logic            in_acc, out_take;
  logic            wrap;
  logic            buf_n;
  logic [CntW-1:0] cnt_n;
  logic [AddrW-1:0] n_w, doff, voff, coff, d_sum, v_sum, c_sum;
  logic            in_pre_busy, in_pre_req, out_pre_busy, out_pre_req;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready = !skid_vld_q;
  assign in_acc = in_i.valid && in_i.ready;
  assign out_take = out_vld_q && out_o.ready;
  assign out_o.valid = out_vld_q;
  assign out_o.data = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interleave_q <= 1'b0;
      start_frame_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.reg_idx)
        psbs_pkg::REG_INTERLEAVE: interleave_q <= cfg_i.data.wdata[0];
        psbs_pkg::REG_START_FRAME: start_frame_q <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  // tick bookkeeping: wrap happens before the refill check
  assign wrap = (cnt_q == CntFull);
  assign buf_n = wrap ? ~active_buf_q : active_buf_q;
  assign cnt_n = wrap ? '0 : cnt_q;
  assign n_w = AddrW'(cnt_n);

  always_comb begin
    if (interleave_q) begin
      doff = n_w;
      voff = n_w << 1;
      coff = voff + AddrW'(1);
    end else begin
      doff = (cur_ch_q ? HalfW : '0) + (n_w >> 1);
      voff = (cur_ch_q ? PktW : '0) + (n_w >> 1);
      coff = voff + HalfW;
    end
    d_sum = (buf_n ? PktW : '0) + doff;
    v_sum = (buf_n ? Pkt2W : '0) + voff;
    c_sum = (buf_n ? Pkt2W : '0) + coff;
  end

  always_comb begin
    active_buf_d = active_buf_q;
    cnt_d = cnt_q;
    cur_ch_d = cur_ch_q;
    in_sbuf_d = in_sbuf_q;
    out_sbuf_d = out_sbuf_q;
    in_pre_req = in_req_q;
    out_pre_req = out_req_q;
    in_pre_busy = in_busy_q;
    out_pre_busy = out_busy_q;
    first_out_d = first_out_q;
    start_pend_d = start_pend_q;
    timer_on_d = timer_on_q;
    res = '0;

    case (in_i.data.op)
      psbs_pkg::OP_ARM: begin
        start_pend_d = 1'b0;
        first_out_d = 1'b0;
        in_pre_busy = 1'b0;
        out_pre_busy = 1'b0;
        in_pre_req = 1'b0;
        out_pre_req = 1'b1;
        active_buf_d = 1'b0;
        out_sbuf_d = 1'b0;
        in_sbuf_d = 1'b0;
        cur_ch_d = 1'b0;
        cnt_d = '0;
      end
      psbs_pkg::OP_TICK: begin
        if (timer_on_q && first_out_q) begin
          if (wrap) begin
            in_sbuf_d = active_buf_q;
            in_pre_req = 1'b1;
          end
          if (cnt_n == CntRefill) begin
            out_sbuf_d = ~buf_n;
            out_pre_req = 1'b1;
          end
          active_buf_d = buf_n;
          cnt_d = cnt_n + CntW'(1);
          cur_ch_d = ~cur_ch_q;
          res.sample_valid = 1'b1;
          res.channel = cur_ch_q;
          res.drive_addr = d_sum[psbs_pkg::DRIVE_AW-1:0];
          res.volt_addr = v_sum[psbs_pkg::CAP_AW-1:0];
          res.curr_addr = c_sum[psbs_pkg::CAP_AW-1:0];
        end
      end
      psbs_pkg::OP_IN_DONE: begin
        if (in_i.data.status_ok) in_pre_busy = 1'b0;
      end
      psbs_pkg::OP_OUT_DONE: begin
        if (in_i.data.status_ok) begin
          if (!first_out_q) start_pend_d = 1'b1;
          first_out_d = 1'b1;
          out_pre_busy = 1'b0;
        end
      end
      psbs_pkg::OP_FRAME: begin
        if (start_pend_q && (in_i.data.frame == start_frame_q || start_frame_q == '0)) begin
          timer_on_d = 1'b1;
          start_pend_d = 1'b0;
        end
      end
      psbs_pkg::OP_STOP: timer_on_d = 1'b0;
      default: ;
    endcase

    // issue a host transfer per direction when requested and idle
    in_req_d = in_pre_req;
    in_busy_d = in_pre_busy;
    if (!in_pre_busy && in_pre_req) begin
      in_req_d = 1'b0;
      in_busy_d = 1'b1;
      res.issue_in = 1'b1;
      res.issue_in_buffer = in_sbuf_d;
    end
    out_req_d = out_pre_req;
    out_busy_d = out_pre_busy;
    if (!out_pre_busy && out_pre_req) begin
      out_req_d = 1'b0;
      out_busy_d = 1'b1;
      res.issue_out = 1'b1;
      res.issue_out_buffer = out_sbuf_d;
    end
    res.running = timer_on_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_buf_q <= 1'b0;
      cnt_q <= '0;
      cur_ch_q <= 1'b0;
      in_sbuf_q <= 1'b0;
      out_sbuf_q <= 1'b0;
      in_req_q <= 1'b0;
      out_req_q <= 1'b0;
      in_busy_q <= 1'b0;
      out_busy_q <= 1'b0;
      first_out_q <= 1'b0;
      start_pend_q <= 1'b0;
      timer_on_q <= 1'b0;
    end else if (in_acc) begin
      active_buf_q <= active_buf_d;
      cnt_q <= cnt_d;
      cur_ch_q <= cur_ch_d;
      in_sbuf_q <= in_sbuf_d;
      out_sbuf_q <= out_sbuf_d;
      in_req_q <= in_req_d;
      out_req_q <= out_req_d;
      in_busy_q <= in_busy_d;
      out_busy_q <= out_busy_d;
      first_out_q <= first_out_d;
      start_pend_q <= start_pend_d;
      timer_on_q <= timer_on_d;
    end
  end

  // output flags; input ready is low while the skid entry is full
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_take || !out_vld_q) begin
      out_vld_q <= skid_vld_q || in_acc;
      skid_vld_q <= 1'b0;
    end else if (in_acc) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take || !out_vld_q) begin
      if (skid_vld_q) out_q <= skid_q;
      else if (in_acc) out_q <= res;
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry full while output entry empty");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("sample count past packet size");

  a_issue_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && res.issue_in |=> in_busy_q && !in_req_q)
    else $error("capture send issued without marking busy");

  a_sample_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && res.sample_valid |-> timer_on_q && first_out_q && res.running)
    else $error("sample produced while timer stopped");

endmodule

// File: bench/tb_pingpong_sample_buffer_sequencer_unit.sv
`timescale 1ns / 100ps

module tb_pingpong_sample_buffer_sequencer_unit;

  localparam int unsigned PKT = psbs_pkg::PACKET_SAMPLES_DEF;
  localparam int unsigned HALF = PKT / 2;
  localparam int unsigned FW = psbs_pkg::FRAME_W;
  localparam int unsigned DAW = psbs_pkg::DRIVE_AW;
  localparam int unsigned CAW = psbs_pkg::CAP_AW;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SESSION_ITEMS = 120;
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [FW-1:0] FRAME_MAX = '1;

  typedef struct {
    psbs_pkg::event_t  ev;
    bit                typed;
    psbs_pkg::result_t res;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  psbs_stream_if #(.payload_t(psbs_pkg::cfg_req_t)) cfg_if ();
  psbs_stream_if #(.payload_t(psbs_pkg::event_t)) in_if ();
  psbs_stream_if #(.payload_t(psbs_pkg::result_t)) out_if ();

  pingpong_sample_buffer_sequencer_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // sequencer state as predicted
  bit          active_buf;
  int unsigned samp_cnt;
  bit          cur_ch;
  bit          in_buf;
  bit          out_buf;
  bit          in_req;
  bit          out_req;
  bit          in_busy_q;
  bit          out_busy_q;
  bit          first_out;
  bit          start_pend;
  bit          timer_run;
  bit          il_mode;
  logic [FW-1:0] sf_reg;

  psbs_pkg::result_t pending_results[$];
  dir_row_t    dir_rows[$];
  int unsigned err_count;
  int unsigned result_idx;
  bit          in_burst;
  bit          out_burst;

  function automatic psbs_pkg::result_t advance_sequencer(input psbs_pkg::event_t ev);
    psbs_pkg::result_t r;
    int unsigned n;
    int unsigned doff;
    int unsigned voff;
    int unsigned coff;
    r = '0;
    case (ev.op)
      psbs_pkg::OP_ARM: begin
        start_pend = 1'b0;
        first_out = 1'b0;
        in_busy_q = 1'b0;
        out_busy_q = 1'b0;
        in_req = 1'b0;
        out_req = 1'b1;
        active_buf = 1'b0;
        out_buf = 1'b0;
        in_buf = 1'b0;
        cur_ch = 1'b0;
        samp_cnt = 0;
      end
      psbs_pkg::OP_TICK: begin
        if (timer_run && first_out) begin
          if (samp_cnt == PKT) begin
            in_buf = active_buf;
            active_buf = ~active_buf;
            samp_cnt = 0;
            in_req = 1'b1;
          end
          // drive refill is requested a little before mid packet
          if (samp_cnt == HALF - 2) begin
            out_buf = ~active_buf;
            out_req = 1'b1;
          end
          n = samp_cnt;
          if (il_mode) begin
            doff = n;
            voff = 2 * n;
            coff = voff + 1;
          end else begin
            doff = cur_ch * HALF + n / 2;
            voff = cur_ch * PKT + n / 2;
            coff = voff + HALF;
          end
          r.sample_valid = 1'b1;
          r.channel = cur_ch;
          r.drive_addr = DAW'(active_buf * PKT + doff);
          r.volt_addr = CAW'(active_buf * 2 * PKT + voff);
          r.curr_addr = CAW'(active_buf * 2 * PKT + coff);
          samp_cnt++;
          cur_ch = ~cur_ch;
        end
      end
      psbs_pkg::OP_IN_DONE: begin
        if (ev.status_ok) in_busy_q = 1'b0;
      end
      psbs_pkg::OP_OUT_DONE: begin
        if (ev.status_ok) begin
          if (!first_out) start_pend = 1'b1;
          first_out = 1'b1;
          out_busy_q = 1'b0;
        end
      end
      psbs_pkg::OP_FRAME: begin
        if (start_pend && (ev.frame == sf_reg || sf_reg == '0)) begin
          timer_run = 1'b1;
          start_pend = 1'b0;
        end
      end
      psbs_pkg::OP_STOP: begin
        timer_run = 1'b0;
      end
      default: ;
    endcase
    if (!in_busy_q && in_req) begin
      in_req = 1'b0;
      in_busy_q = 1'b1;
      r.issue_in = 1'b1;
      r.issue_in_buffer = in_buf;
    end
    if (!out_busy_q && out_req) begin
      out_req = 1'b0;
      out_busy_q = 1'b1;
      r.issue_out = 1'b1;
      r.issue_out_buffer = out_buf;
    end
    r.running = timer_run;
    return r;
  endfunction

  function automatic psbs_pkg::event_t mk_event(input logic [2:0] op, input logic ok,
                                                input logic [FW-1:0] fr);
    psbs_pkg::event_t ev;
    ev.op = psbs_pkg::op_e'(op);
    ev.status_ok = ok;
    ev.frame = fr;
    return ev;
  endfunction

  function automatic psbs_pkg::result_t quiet_result(input bit run, input bit iss_out);
    psbs_pkg::result_t r;
    r = '0;
    r.running = run;
    r.issue_out = iss_out;
    return r;
  endfunction

  function automatic int draw_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic void add_row(input logic [2:0] op, input logic ok,
                                  input logic [FW-1:0] fr, input bit typed,
                                  input psbs_pkg::result_t res);
    dir_row_t row;
    row.ev = mk_event(op, ok, fr);
    row.typed = typed;
    row.res = res;
    dir_rows.push_back(row);
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < 40) $display("ERROR result %0d: %s", result_idx, msg);
    err_count++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  // one request per call; valid stays high across back-to-back requests
  task automatic send_event(input psbs_pkg::event_t ev, input bit typed,
                            input psbs_pkg::result_t typed_res);
    int                gap;
    psbs_pkg::result_t predicted;
    gap = draw_gap(in_burst);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= ev;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predicted = advance_sequencer(ev);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic send_op(input logic [2:0] op, input logic ok, input logic [FW-1:0] fr);
    send_event(mk_event(op, ok, fr), 1'b0, '0);
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [FW-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{reg_idx: idx, wdata: val};
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    if (idx == psbs_pkg::REG_INTERLEAVE) il_mode = val[0];
    else sf_reg = val;
  endtask

  task automatic run_session(input bit il, input logic [FW-1:0] sf, input int items);
    int unsigned r;
    logic [2:0]  op;
    logic [FW-1:0] fr;
    wait_drain();
    write_cfg(psbs_pkg::REG_INTERLEAVE, {{(FW-1){1'b0}}, il});
    write_cfg(psbs_pkg::REG_START_FRAME, sf);
    // well-formed start: arm, first drive buffer in, matching frame
    send_op(psbs_pkg::OP_ARM, 1'($urandom_range(0, 1)), FW'($urandom_range(0, 2047)));
    if ($urandom_range(0, 1))
      send_op(psbs_pkg::OP_OUT_DONE, 1'b0, FW'($urandom_range(0, 2047)));
    send_op(psbs_pkg::OP_OUT_DONE, 1'b1, FW'($urandom_range(0, 2047)));
    if (sf != '0) begin
      repeat ($urandom_range(0, 3))
        send_op(psbs_pkg::OP_FRAME, 1'b1, FW'($urandom_range(0, 2047)));
      send_op(psbs_pkg::OP_FRAME, 1'($urandom_range(0, 1)), sf);
    end else begin
      send_op(psbs_pkg::OP_FRAME, 1'($urandom_range(0, 1)), FW'($urandom_range(0, 2047)));
    end
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 39) == 0) in_burst = ~in_burst;
      if (i == items / 2) wait_drain();
      r = $urandom_range(0, 999);
      fr = FW'($urandom_range(0, 2047));
      if (r < 800) op = psbs_pkg::OP_TICK;
      else if (r < 870) op = psbs_pkg::OP_IN_DONE;
      else if (r < 930) op = psbs_pkg::OP_OUT_DONE;
      else if (r < 975) begin
        op = psbs_pkg::OP_FRAME;
        if ($urandom_range(0, 1)) fr = sf;
      end
      else if (r < 985) op = OP_SPARE_LO;
      else if (r < 994) op = OP_SPARE_HI;
      else if (r < 997) op = psbs_pkg::OP_STOP;
      else op = psbs_pkg::OP_ARM;
      send_op(op, $urandom_range(0, 3) != 0, fr);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    psbs_pkg::result_t want;
    psbs_pkg::result_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = pending_results.pop_front();
        compare_field("sample_valid", int'(got.sample_valid), int'(want.sample_valid));
        compare_field("channel", int'(got.channel), int'(want.channel));
        compare_field("drive_addr", int'(got.drive_addr), int'(want.drive_addr));
        compare_field("volt_addr", int'(got.volt_addr), int'(want.volt_addr));
        compare_field("curr_addr", int'(got.curr_addr), int'(want.curr_addr));
        compare_field("issue_in", int'(got.issue_in), int'(want.issue_in));
        compare_field("issue_in_buffer", int'(got.issue_in_buffer),
                      int'(want.issue_in_buffer));
        compare_field("issue_out", int'(got.issue_out), int'(want.issue_out));
        compare_field("issue_out_buffer", int'(got.issue_out_buffer),
                      int'(want.issue_out_buffer));
        compare_field("running", int'(got.running), int'(want.running));
      end
      result_idx++;
    end
  end

  // result side back-pressure
  initial begin : drive_ready
    int gap;
    out_if.ready <= 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0) out_burst = ~out_burst;
      gap = draw_gap(out_burst);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : main
    in_if.valid <= 1'b0;
    in_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;
    err_count = 0;
    result_idx = 0;
    in_burst = 1'b0;
    out_burst = 1'b0;
    active_buf = 1'b0;
    samp_cnt = 0;
    cur_ch = 1'b0;
    in_buf = 1'b0;
    out_buf = 1'b0;
    in_req = 1'b0;
    out_req = 1'b0;
    in_busy_q = 1'b0;
    out_busy_q = 1'b0;
    first_out = 1'b0;
    start_pend = 1'b0;
    timer_run = 1'b0;
    il_mode = 1'b0;
    sf_reg = '0;

    // directed part, reset config: planar, start on any frame
    add_row(psbs_pkg::OP_TICK, 1'b1, FRAME_MAX, 1'b1, quiet_result(1'b0, 1'b0));
    add_row(psbs_pkg::OP_STOP, 1'b1, '0, 1'b1, quiet_result(1'b0, 1'b0));
    add_row(OP_SPARE_LO, 1'b1, FRAME_MAX, 1'b1, quiet_result(1'b0, 1'b0));
    add_row(OP_SPARE_HI, 1'b0, '0, 1'b1, quiet_result(1'b0, 1'b0));
    // frame with no start pending
    add_row(psbs_pkg::OP_FRAME, 1'b1, FRAME_MAX, 1'b1, quiet_result(1'b0, 1'b0));
    // completion with nothing in flight
    add_row(psbs_pkg::OP_IN_DONE, 1'b1, '0, 1'b1, quiet_result(1'b0, 1'b0));
    add_row(psbs_pkg::OP_OUT_DONE, 1'b0, '0, 1'b1, quiet_result(1'b0, 1'b0));
    add_row(psbs_pkg::OP_ARM, 1'b0, '0, 1'b1, quiet_result(1'b0, 1'b1));
    // tick before the first drive buffer arrives
    add_row(psbs_pkg::OP_TICK, 1'b0, '0, 1'b1, quiet_result(1'b0, 1'b0));
    add_row(psbs_pkg::OP_OUT_DONE, 1'b0, FRAME_MAX, 1'b1, quiet_result(1'b0, 1'b0));
    add_row(psbs_pkg::OP_FRAME, 1'b0, '0, 1'b1, quiet_result(1'b0, 1'b0));
    add_row(psbs_pkg::OP_OUT_DONE, 1'b1, '0, 1'b0, '0);
    add_row(psbs_pkg::OP_FRAME, 1'b0, FRAME_MAX, 1'b0, '0);
    repeat (4) add_row(psbs_pkg::OP_TICK, 1'b0, '0, 1'b0, '0);
    add_row(psbs_pkg::OP_IN_DONE, 1'b0, '0, 1'b0, '0);
    add_row(psbs_pkg::OP_OUT_DONE, 1'b1, FRAME_MAX, 1'b0, '0);
    add_row(psbs_pkg::OP_FRAME, 1'b1, '0, 1'b0, '0);
    add_row(psbs_pkg::OP_TICK, 1'b1, FRAME_MAX, 1'b0, '0);
    add_row(psbs_pkg::OP_STOP, 1'b0, FRAME_MAX, 1'b0, '0);
    add_row(psbs_pkg::OP_TICK, 1'b1, '0, 1'b0, '0);
    add_row(psbs_pkg::OP_ARM, 1'b1, FRAME_MAX, 1'b0, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_rows[i]) send_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].res);

    run_session(1'b0, '0, SESSION_ITEMS);
    run_session(1'b1, FRAME_MAX, SESSION_ITEMS);
    run_session(1'b1, FW'($urandom_range(1, 2046)), SESSION_ITEMS);
    run_session(1'b0, FW'($urandom_range(1, 2046)), SESSION_ITEMS);

    wait_drain();
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (err_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
design/psbs_pkg.sv
design/psbs_stream_if.sv
design/pingpong_sample_buffer_sequencer_unit.sv
bench/tb_pingpong_sample_buffer_sequencer_unit.sv
